FILE: rtl/jpeg_restart_interval_tiler_top_assert.svh
// Assertion macros for the restart interval tiler.
`ifndef JPEG_RESTART_INTERVAL_TILER_TOP_ASSERT_SVH
`define JPEG_RESTART_INTERVAL_TILER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define JRIT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("tiler assertion failed");

// next-cycle implication, disabled while reset is asserted
`define JRIT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("tiler assertion failed");

`endif

FILE: rtl/jrit_pkg.sv
// Types and constants of the restart interval tiler.
package jrit_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [4:0] tile_index;
		logic       to_all_tiles;
		logic       final_byte;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_SCANHDR = 4'b0010,
		PH_ENTROPY = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		CFG_TILE_WIDTH    = 3'd0,
		CFG_TILE_HEIGHT   = 3'd1,
		CFG_TILE_COLUMNS  = 3'd2,
		CFG_TILE_ROWS     = 3'd3,
		CFG_INTERVALS     = 3'd4,
		CFG_MCU_ROWS      = 3'd5,
		CFG_SCAN_HDR_LEN  = 3'd6
	} cfg_index_t;

	localparam logic [7:0] MK_FF   = 8'hFF;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_SOF0 = 8'hC0;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;
	localparam logic [7:0] MK_EOI  = 8'hD9;

	localparam logic [3:0] SOF_HEIGHT_HI = 4'd4;
	localparam logic [3:0] SOF_HEIGHT_LO = 4'd5;
	localparam logic [3:0] SOF_WIDTH_HI  = 4'd6;
	localparam logic [3:0] SOF_WIDTH_LO  = 4'd7;

	localparam int FIFO_DEPTH = 4;

endpackage

FILE: rtl/jpeg_restart_interval_tiler_top.sv
// Restart interval tiler: splits a JPEG byte stream into tile streams.
//
// Source bytes arrive on byte_valid/byte_stall/byte_item, one request per
// byte with end_of_file on the last byte. Tagged output bytes leave on
// result_valid/result_stall/result_item, each naming a tile or all tiles.
// The user must write registers on cfg_valid/cfg_ready/cfg_index/cfg_data
// only while the block is idle (not enforced); cfg_ready is always high.
//
// An accepted byte is registered in item_s1 and decoded there; its
// results are written into the output queue when the byte issues and
// are offered from there. Each byte yields zero to three results; the
// queue holds four entries and the decoded byte issues once it has room
// for all of them. One byte per cycle is sustained while bytes give at
// most one result each and the receiver does not stall; a byte that
// gives more can stall the source until the single port drains the queue.
//
// Reset empties the queue and returns stream state and registers to their
// defaults. A stalled receiver fills the queue, after which byte_stall
// rises until entries drain.
`include "jpeg_restart_interval_tiler_top_assert.svh"

module jpeg_restart_interval_tiler_top #(
	parameter int MAX_TILES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  jrit_pkg::in_item_t byte_item,
	output logic               result_valid,
	input  logic               result_stall,
	output jrit_pkg::out_item_t result_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import jrit_pkg::*;

	localparam int NUM_RST = (MAX_TILES < 32) ? MAX_TILES : 32;
	localparam int RIDX_W = (NUM_RST > 1) ? $clog2(NUM_RST) : 1;
	localparam logic [4:0] TILE_LIMIT = 5'(NUM_RST - 1);

	logic [15:0] tile_width_q, tile_height_q;
	logic [5:0]  tile_columns_q, tile_rows_q;
	logic [13:0] intervals_q, mcu_rows_q;
	logic [7:0]  scan_hdr_len_q;

	logic        valid_s1;
	in_item_t    item_s1;

	phase_t      phase_q, phase_d;
	logic        pend_ff_q, pend_ff_d;
	logic [3:0]  pos_q, pos_d;
	logic        rewritten_q, rewritten_d;
	logic [7:0]  shl_q, shl_d;
	logic [13:0] iv_q, iv_d;
	logic [4:0]  col_q, col_d;
	logic [13:0] mrow_q, mrow_d;
	logic [4:0]  row_q, row_d;
	logic [2:0]  rst_num_q [NUM_RST];

	out_item_t   fifo_q [FIFO_DEPTH];
	logic [1:0]  rd_ptr_q, wr_ptr_q;
	logic [2:0]  count_q;

	out_item_t   res [3];
	logic [1:0]  n_res;
	logic        rst_wr, rst_clr;
	logic        issue, accept, pop;

	logic [11:0] idx_full;
	logic [4:0]  tile_now;
	logic [RIDX_W-1:0] ridx;
	logic [2:0]  rn;
	logic [13:0] iv_inc, mrow_inc;
	logic [5:0]  col_inc, top6;
	logic [4:0]  top5;
	logic [7:0]  b;
	logic        eof, was_ff;

	function automatic out_item_t mk(input logic [7:0] v, input logic [4:0] t,
			input logic all, input logic fin);
		out_item_t r;
		r.out_byte = v;
		r.tile_index = all ? 5'd0 : t;
		r.to_all_tiles = all;
		r.final_byte = fin;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q <= 16'd1280;
			tile_height_q <= 16'd768;
			tile_columns_q <= 6'd4;
			tile_rows_q <= 6'd5;
			intervals_q <= 14'd20;
			mcu_rows_q <= 14'd96;
			scan_hdr_len_q <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TILE_WIDTH:   tile_width_q <= cfg_data;
				CFG_TILE_HEIGHT:  tile_height_q <= cfg_data;
				CFG_TILE_COLUMNS: tile_columns_q <= cfg_data[5:0];
				CFG_TILE_ROWS:    tile_rows_q <= cfg_data[5:0];
				CFG_INTERVALS:    intervals_q <= cfg_data[13:0];
				CFG_MCU_ROWS:     mcu_rows_q <= cfg_data[13:0];
				CFG_SCAN_HDR_LEN: scan_hdr_len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign b = item_s1.in_byte;
	assign eof = item_s1.end_of_file;
	assign was_ff = pend_ff_q;

	assign idx_full = 12'(col_q) + 12'(row_q * tile_columns_q);
	assign tile_now = (idx_full > 12'(TILE_LIMIT)) ? TILE_LIMIT : idx_full[4:0];
	assign ridx = tile_now[RIDX_W-1:0];
	assign rn = rst_num_q[ridx];

	assign iv_inc = iv_q + 14'd1;
	assign mrow_inc = mrow_q + 14'd1;
	assign col_inc = {1'b0, col_q} + 6'd1;
	assign top6 = (tile_rows_q == 6'd0) ? 6'd0 : tile_rows_q - 6'd1;
	assign top5 = (top6 > 6'd31) ? 5'd31 : top6[4:0];

	always_comb begin
		logic adv, scan;
		logic [7:0] o;
		adv = 1'b0;
		scan = 1'b0;
		o = b;
		phase_d = phase_q;
		pend_ff_d = pend_ff_q;
		pos_d = pos_q;
		rewritten_d = rewritten_q;
		shl_d = shl_q;
		iv_d = iv_q;
		col_d = col_q;
		mrow_d = mrow_q;
		row_d = row_q;
		rst_wr = 1'b0;
		rst_clr = 1'b0;
		n_res = 2'd0;
		for (int k = 0; k < 3; k++) begin
			res[k] = mk(8'd0, 5'd0, 1'b0, 1'b0);
		end

		case (phase_q)
			PH_HEADER: begin
				if (pos_q != 4'd0) begin
					case (pos_q)
						SOF_HEIGHT_HI: o = tile_height_q[15:8];
						SOF_HEIGHT_LO: o = tile_height_q[7:0];
						SOF_WIDTH_HI:  o = tile_width_q[15:8];
						SOF_WIDTH_LO:  o = tile_width_q[7:0];
						default:       o = b;
					endcase
					pos_d = (pos_q >= SOF_WIDTH_LO) ? 4'd0 : pos_q + 4'd1;
				end
				res[n_res] = mk(o, 5'd0, 1'b1, was_ff && b == MK_EOI);
				n_res = n_res + 2'd1;
				pend_ff_d = (b == MK_FF);
				if (was_ff && b == MK_SOS) begin
					scan = 1'b1;
				end else if (was_ff && b == MK_EOI) begin
					phase_d = PH_DONE;
					pos_d = 4'd0;
					pend_ff_d = 1'b0;
				end else if (was_ff && b == MK_SOF0 && pos_q == 4'd0 && !rewritten_q) begin
					pos_d = 4'd1;
					rewritten_d = 1'b1;
				end
			end
			PH_SCANHDR: begin
				res[n_res] = mk(b, 5'd0, 1'b1, 1'b0);
				n_res = n_res + 2'd1;
				pend_ff_d = 1'b0;
				shl_d = (shl_q != 8'd0) ? shl_q - 8'd1 : 8'd0;
				if (shl_d == 8'd0) begin
					phase_d = PH_ENTROPY;
				end
			end
			PH_ENTROPY: begin
				if (!was_ff) begin
					if (b == MK_FF) begin
						pend_ff_d = 1'b1;
					end else begin
						res[n_res] = mk(b, tile_now, 1'b0, 1'b0);
						n_res = n_res + 2'd1;
					end
				end else if (eof && b != MK_EOI) begin
					pend_ff_d = 1'b0;
				end else if (b >= MK_RST0 && b <= MK_RST7) begin
					res[0] = mk(MK_FF, tile_now, 1'b0, 1'b0);
					res[1] = mk(MK_RST0 + 8'(rn), tile_now, 1'b0, 1'b0);
					n_res = 2'd2;
					rst_wr = 1'b1;
					adv = 1'b1;
					pend_ff_d = 1'b0;
				end else if (b == MK_SOS) begin
					res[0] = mk(MK_FF, 5'd0, 1'b1, 1'b0);
					res[1] = mk(MK_SOS, 5'd0, 1'b1, 1'b0);
					n_res = 2'd2;
					scan = 1'b1;
				end else if (b == MK_EOI) begin
					res[0] = mk(MK_FF, 5'd0, 1'b1, 1'b0);
					res[1] = mk(MK_EOI, 5'd0, 1'b1, 1'b1);
					n_res = 2'd2;
					phase_d = PH_DONE;
					pend_ff_d = 1'b0;
				end else if (b == MK_FF) begin
					res[0] = mk(MK_FF, tile_now, 1'b0, 1'b0);
					n_res = 2'd1;
				end else begin
					res[0] = mk(MK_FF, tile_now, 1'b0, 1'b0);
					res[1] = mk(b, tile_now, 1'b0, 1'b0);
					n_res = 2'd2;
					pend_ff_d = 1'b0;
				end
			end
			default: ;
		endcase

		if (adv) begin
			if (iv_inc < intervals_q) begin
				iv_d = iv_inc;
			end else begin
				iv_d = 14'd0;
				if (col_inc < tile_columns_q && col_inc <= 6'd31) begin
					col_d = col_inc[4:0];
				end else begin
					col_d = 5'd0;
					if (mrow_inc < mcu_rows_q) begin
						mrow_d = mrow_inc;
					end else begin
						mrow_d = 14'd0;
						row_d = (row_q < top5) ? row_q + 5'd1 : top5;
					end
				end
			end
		end

		if (scan) begin
			iv_d = 14'd0;
			col_d = 5'd0;
			mrow_d = 14'd0;
			row_d = 5'd0;
			rst_clr = 1'b1;
			shl_d = scan_hdr_len_q;
			phase_d = (scan_hdr_len_q != 8'd0) ? PH_SCANHDR : PH_ENTROPY;
			pos_d = 4'd0;
			pend_ff_d = 1'b0;
		end

		if (eof) begin
			if (phase_d != PH_DONE) begin
				res[n_res] = mk(MK_FF, 5'd0, 1'b1, 1'b0);
				res[n_res + 2'd1] = mk(MK_EOI, 5'd0, 1'b1, 1'b1);
				n_res = n_res + 2'd2;
			end
			phase_d = PH_HEADER;
			pend_ff_d = 1'b0;
			pos_d = 4'd0;
			rewritten_d = 1'b0;
			shl_d = 8'd0;
			iv_d = 14'd0;
			col_d = 5'd0;
			mrow_d = 14'd0;
			row_d = 5'd0;
			rst_clr = 1'b1;
		end
	end

	assign issue = valid_s1 && ((count_q + 3'(n_res)) <= 3'(FIFO_DEPTH));
	assign byte_stall = valid_s1 && !issue;
	assign accept = byte_valid && !byte_stall;
	assign result_valid = (count_q != 3'd0);
	assign result_item = fifo_q[rd_ptr_q];
	assign pop = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (issue) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pend_ff_q <= 1'b0;
			pos_q <= 4'd0;
			rewritten_q <= 1'b0;
			shl_q <= 8'd0;
			iv_q <= 14'd0;
			col_q <= 5'd0;
			mrow_q <= 14'd0;
			row_q <= 5'd0;
			for (int k = 0; k < NUM_RST; k++) begin
				rst_num_q[k] <= 3'd0;
			end
		end else if (issue) begin
			phase_q <= phase_d;
			pend_ff_q <= pend_ff_d;
			pos_q <= pos_d;
			rewritten_q <= rewritten_d;
			shl_q <= shl_d;
			iv_q <= iv_d;
			col_q <= col_d;
			mrow_q <= mrow_d;
			row_q <= row_d;
			if (rst_clr) begin
				for (int k = 0; k < NUM_RST; k++) begin
					rst_num_q[k] <= 3'd0;
				end
			end else if (rst_wr) begin
				rst_num_q[ridx] <= rn + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (issue) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			count_q <= count_q + (issue ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < n_res) begin
					fifo_q[wr_ptr_q + 2'(k)] <= res[k];
				end
			end
		end
	end

	`JRIT_ASSERT_IMPLY(a_queue_bound, clk, arst_n, 1'b1, count_q <= 3'(FIFO_DEPTH))
	`JRIT_ASSERT_IMPLY(a_final_is_bcast, clk, arst_n, result_valid && result_item.final_byte,
		result_item.to_all_tiles)
	`JRIT_ASSERT_IMPLY(a_bcast_tile0, clk, arst_n, result_valid && result_item.to_all_tiles,
		result_item.tile_index == 5'd0)
	`JRIT_ASSERT_NEXT(a_eof_resets, clk, arst_n, issue && item_s1.end_of_file,
		phase_q == PH_HEADER && !pend_ff_q && !rewritten_q)

endmodule
